/* hw/rtl/cftm_pkg.sv */
// Shared constants and types of the cyclic frame task monitor.
package cftm_pkg;

	localparam int NumTasks   = 16;
	localparam int NumFrames  = 16;
	localparam int CountWidth = 16;

	localparam int TaskIdxWidth  = 4;
	localparam int FrameIdxWidth = 4;
	localparam int UseWidth      = 5;
	localparam int MaskWidth     = 16;
	localparam int HyperWidth    = 16;
	localparam int ReqWidth      = 3;
	localparam int CfgIdxWidth   = 1;

	typedef logic [CountWidth-1:0] count_t;
	typedef logic [MaskWidth-1:0]  mask_t;
	typedef logic [1:0]            status_t;

	// task status codes
	localparam status_t ST_IDLE    = 2'd0;
	localparam status_t ST_PENDING = 2'd1;
	localparam status_t ST_RUNNING = 2'd2;
	localparam status_t ST_MISSED  = 2'd3;

	// request codes
	localparam logic [ReqWidth-1:0] REQ_LOAD    = 3'd0;
	localparam logic [ReqWidth-1:0] REQ_START   = 3'd1;
	localparam logic [ReqWidth-1:0] REQ_FINISH  = 3'd2;
	localparam logic [ReqWidth-1:0] REQ_RELEASE = 3'd3;
	localparam logic [ReqWidth-1:0] REQ_END     = 3'd4;

	// configuration register indexes
	localparam logic [CfgIdxWidth-1:0] CFG_TASKS  = 1'd0;
	localparam logic [CfgIdxWidth-1:0] CFG_FRAMES = 1'd1;

	// counter select for the shared incrementer
	typedef enum logic [1:0] {
		BUMP_NONE,
		BUMP_MISS,
		BUMP_CANCEL,
		BUMP_DONE
	} bump_t;

	function automatic logic [UseWidth-1:0] clamp_use(input logic [UseWidth-1:0] v,
			input logic [UseWidth-1:0] hi);
		logic [UseWidth-1:0] r;
		r = v;
		if (v == '0)
			r = UseWidth'(1);
		else if (v > hi)
			r = hi;
		return r;
	endfunction

endpackage

/* hw/rtl/cyclic_frame_task_monitor_core.sv */
// Cyclic-executive frame monitor: task status, frame table and per-task counters.
// A load word is taken in its accept cycle and leaves the input free; an unknown request is
// dropped the same way. A start or finish word holds the input while its task entry is
// updated. A release word walks tasks_in_use task entries one per cycle while no held report
// is stalled at the output, and gives its one report with the last entry; a frame-end word
// walks the same entries one per cycle under the same condition and gives one report per
// task. All per-task updates go through one saturating counter incrementer and one status
// decoder that step across the task entries; the input is stalled while a word is being
// walked. Counters saturate at all ones, the hyperperiod count wraps.
module cyclic_frame_task_monitor_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cftm_pkg::CfgIdxWidth-1:0]   cfg_index,
	input  logic [cftm_pkg::UseWidth-1:0]      cfg_data,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [cftm_pkg::ReqWidth-1:0]      req_type,
	input  logic [cftm_pkg::TaskIdxWidth-1:0]  task_index,
	input  logic [cftm_pkg::FrameIdxWidth-1:0] frame_index,
	input  logic [cftm_pkg::MaskWidth-1:0]     task_mask,
	// output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               report_kind,
	output logic [cftm_pkg::TaskIdxWidth-1:0]  report_task,
	output logic [1:0]                         task_state,
	output logic [cftm_pkg::CountWidth-1:0]    miss_total,
	output logic [cftm_pkg::CountWidth-1:0]    cancel_total,
	output logic [cftm_pkg::CountWidth-1:0]    done_total,
	output logic [cftm_pkg::HyperWidth-1:0]    hyperperiod_count,
	output logic [cftm_pkg::MaskWidth-1:0]     released_mask,
	output logic [cftm_pkg::MaskWidth-1:0]     demoted_mask,
	output logic                               last
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_STEP = 1'b1;

	localparam logic [cftm_pkg::UseWidth-1:0] MaxTasksUse  =
		cftm_pkg::UseWidth'(cftm_pkg::NumTasks);
	localparam logic [cftm_pkg::UseWidth-1:0] MaxFramesUse =
		cftm_pkg::UseWidth'(cftm_pkg::NumFrames);

	logic state_q;
	logic [cftm_pkg::ReqWidth-1:0]      req_q;
	logic [cftm_pkg::TaskIdxWidth-1:0]  idx_q;
	cftm_pkg::mask_t                    members_q;
	cftm_pkg::mask_t                    rel_q;
	cftm_pkg::mask_t                    dem_q;
	logic [cftm_pkg::UseWidth-1:0]      tasks_q;
	logic [cftm_pkg::UseWidth-1:0]      frames_q;
	logic [cftm_pkg::FrameIdxWidth-1:0] frame_q;
	logic [cftm_pkg::HyperWidth-1:0]    hyper_q;

	cftm_pkg::status_t status_q [cftm_pkg::NumTasks];
	logic              ovr_q    [cftm_pkg::NumTasks];
	cftm_pkg::count_t  miss_q   [cftm_pkg::NumTasks];
	cftm_pkg::count_t  cancel_q [cftm_pkg::NumTasks];
	cftm_pkg::count_t  done_q   [cftm_pkg::NumTasks];
	cftm_pkg::mask_t   ftab_q   [cftm_pkg::NumFrames];

	logic out_valid_q;
	logic kind_q, last_q;
	logic [cftm_pkg::TaskIdxWidth-1:0] rtask_q;
	cftm_pkg::status_t                 rstate_q;
	cftm_pkg::count_t                  rmiss_q, rcancel_q, rdone_q;
	logic [cftm_pkg::HyperWidth-1:0]   rhyper_q;
	cftm_pkg::mask_t                   rrel_q, rdem_q;

	logic in_fire, out_free, step_go, out_load, last_idx;
	cftm_pkg::status_t cur_st, next_st;
	logic cur_ov, next_ov, mem_bit;
	cftm_pkg::bump_t bump_sel;
	cftm_pkg::count_t cnt_sel, cnt_inc, new_miss, new_cancel, new_done;
	cftm_pkg::mask_t idx_bit, rel_next, dem_next;
	logic [cftm_pkg::UseWidth-1:0] frame_nx;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign cur_st  = status_q[idx_q];
	assign cur_ov  = ovr_q[idx_q];
	assign mem_bit = members_q[idx_q];
	assign idx_bit = cftm_pkg::mask_t'(1) << idx_q;
	assign last_idx = ({1'b0, idx_q} + cftm_pkg::UseWidth'(1)) >= tasks_q;
	assign frame_nx = {1'b0, frame_q} + cftm_pkg::UseWidth'(1);

	// per-task decision for the word under way
	always_comb begin
		next_st  = cur_st;
		next_ov  = cur_ov;
		bump_sel = cftm_pkg::BUMP_NONE;
		unique case (req_q)
			cftm_pkg::REQ_START: begin
				if (cur_st != cftm_pkg::ST_IDLE)
					next_st = cftm_pkg::ST_RUNNING;
			end
			cftm_pkg::REQ_FINISH: begin
				next_st = cftm_pkg::ST_IDLE;
			end
			cftm_pkg::REQ_RELEASE: begin
				if (mem_bit) begin
					if (cur_st == cftm_pkg::ST_IDLE)
						next_st = cftm_pkg::ST_PENDING;
					else if (cur_st == cftm_pkg::ST_MISSED)
						bump_sel = cftm_pkg::BUMP_CANCEL;
				end
			end
			cftm_pkg::REQ_END: begin
				unique case (cur_st)
					cftm_pkg::ST_RUNNING: begin
						next_st  = cftm_pkg::ST_MISSED;
						next_ov  = 1'b1;
						bump_sel = cftm_pkg::BUMP_MISS;
					end
					cftm_pkg::ST_PENDING: begin
						if (cur_ov) begin
							next_st  = cftm_pkg::ST_MISSED;
							bump_sel = cftm_pkg::BUMP_MISS;
						end else begin
							next_st  = cftm_pkg::ST_IDLE;
							bump_sel = cftm_pkg::BUMP_CANCEL;
						end
					end
					cftm_pkg::ST_IDLE: begin
						if (cur_ov)
							next_ov = 1'b0;
						else if (mem_bit)
							bump_sel = cftm_pkg::BUMP_DONE;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// shared saturating incrementer
	always_comb begin
		unique case (bump_sel)
			cftm_pkg::BUMP_MISS:   cnt_sel = miss_q[idx_q];
			cftm_pkg::BUMP_CANCEL: cnt_sel = cancel_q[idx_q];
			cftm_pkg::BUMP_DONE:   cnt_sel = done_q[idx_q];
			default:               cnt_sel = '0;
		endcase
		cnt_inc = (&cnt_sel) ? cnt_sel : cnt_sel + cftm_pkg::count_t'(1);
		new_miss   = (bump_sel == cftm_pkg::BUMP_MISS)   ? cnt_inc : miss_q[idx_q];
		new_cancel = (bump_sel == cftm_pkg::BUMP_CANCEL) ? cnt_inc : cancel_q[idx_q];
		new_done   = (bump_sel == cftm_pkg::BUMP_DONE)   ? cnt_inc : done_q[idx_q];
	end

	assign rel_next = (next_st == cftm_pkg::ST_PENDING && cur_st == cftm_pkg::ST_IDLE) ?
		(rel_q | idx_bit) : rel_q;
	assign dem_next = (cur_st == cftm_pkg::ST_MISSED) ? (dem_q | idx_bit) : dem_q;

	always_comb begin
		step_go = 1'b0;
		if (state_q == S_STEP) begin
			if (req_q == cftm_pkg::REQ_RELEASE || req_q == cftm_pkg::REQ_END)
				step_go = out_free;
			else
				step_go = 1'b1;
		end
	end
	assign out_load = step_go && ((req_q == cftm_pkg::REQ_END) ||
		(req_q == cftm_pkg::REQ_RELEASE && last_idx));

	// sequencer, configuration and task state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			req_q    <= cftm_pkg::REQ_LOAD;
			idx_q    <= '0;
			tasks_q  <= MaxTasksUse;
			frames_q <= cftm_pkg::UseWidth'(1);
			frame_q  <= '0;
			hyper_q  <= '0;
			for (int i = 0; i < cftm_pkg::NumTasks; i++) begin
				status_q[i] <= cftm_pkg::ST_IDLE;
				ovr_q[i]    <= 1'b0;
				miss_q[i]   <= '0;
				cancel_q[i] <= '0;
				done_q[i]   <= '0;
			end
			for (int f = 0; f < cftm_pkg::NumFrames; f++)
				ftab_q[f] <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == cftm_pkg::CFG_TASKS)
					tasks_q <= cftm_pkg::clamp_use(cfg_data, MaxTasksUse);
				else if (cfg_index == cftm_pkg::CFG_FRAMES)
					frames_q <= cftm_pkg::clamp_use(cfg_data, MaxFramesUse);
			end
			if (in_fire) begin
				req_q <= req_type;
				unique case (req_type)
					cftm_pkg::REQ_LOAD: begin
						ftab_q[frame_index] <= task_mask;
					end
					cftm_pkg::REQ_START, cftm_pkg::REQ_FINISH: begin
						idx_q   <= task_index;
						state_q <= S_STEP;
					end
					cftm_pkg::REQ_RELEASE, cftm_pkg::REQ_END: begin
						idx_q   <= '0;
						state_q <= S_STEP;
					end
					default: begin
					end
				endcase
			end
			if (step_go) begin
				status_q[idx_q] <= next_st;
				ovr_q[idx_q]    <= next_ov;
				miss_q[idx_q]   <= new_miss;
				cancel_q[idx_q] <= new_cancel;
				done_q[idx_q]   <= new_done;
				idx_q           <= idx_q + cftm_pkg::TaskIdxWidth'(1);
				if (req_q == cftm_pkg::REQ_START || req_q == cftm_pkg::REQ_FINISH || last_idx)
					state_q <= S_IDLE;
				if (req_q == cftm_pkg::REQ_END && last_idx) begin
					if (frame_nx >= frames_q) begin
						frame_q <= '0;
						hyper_q <= hyper_q + cftm_pkg::HyperWidth'(1);
					end else begin
						frame_q <= frame_nx[cftm_pkg::FrameIdxWidth-1:0];
					end
				end
			end
		end
	end

	// per-word scratch: frame members and release masks
	always_ff @(posedge clk) begin
		if (in_fire) begin
			members_q <= ftab_q[frame_q];
			rel_q     <= '0;
			dem_q     <= '0;
		end else if (step_go) begin
			rel_q <= rel_next;
			dem_q <= dem_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rhyper_q <= hyper_q;
			last_q   <= last_idx;
			if (req_q == cftm_pkg::REQ_END) begin
				kind_q    <= 1'b1;
				rtask_q   <= idx_q;
				rstate_q  <= next_st;
				rmiss_q   <= new_miss;
				rcancel_q <= new_cancel;
				rdone_q   <= new_done;
				rrel_q    <= '0;
				rdem_q    <= '0;
			end else begin
				kind_q    <= 1'b0;
				rtask_q   <= '0;
				rstate_q  <= cftm_pkg::ST_IDLE;
				rmiss_q   <= '0;
				rcancel_q <= '0;
				rdone_q   <= '0;
				rrel_q    <= rel_next;
				rdem_q    <= dem_next;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign report_kind       = kind_q;
	assign report_task       = rtask_q;
	assign task_state        = rstate_q;
	assign miss_total        = rmiss_q;
	assign cancel_total      = rcancel_q;
	assign done_total        = rdone_q;
	assign hyperperiod_count = rhyper_q;
	assign released_mask     = rrel_q;
	assign demoted_mask      = rdem_q;
	assign last              = last_q;

`ifndef ASSERT_OFF
	// a task is never both released and demoted in one release
	a_rel_dem_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !report_kind |-> (released_mask & demoted_mask) == '0)
		else $error("release and demote masks overlap");

	// a frame-end report names the task that was just stepped
	a_report_task: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && req_q == cftm_pkg::REQ_END |=> report_task == $past(idx_q))
		else $error("frame-end report carries wrong task");

	// the final report of a word frees the sequencer
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && last_idx |=> state_q == S_IDLE)
		else $error("sequencer still busy after last report");

	// no report is loaded over one that is still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !(out_valid_q && out_stall))
		else $error("output word overwritten while stalled");
`endif

endmodule

/* tb/sv/cftm_report_checker.sv */
// Report checker for the cyclic frame task monitor: predicts every report and compares it.
module cftm_report_checker
	import cftm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CfgIdxWidth-1:0]   cfg_index,
	input  logic [UseWidth-1:0]      cfg_data,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [ReqWidth-1:0]      req_type,
	input  logic [TaskIdxWidth-1:0]  task_index,
	input  logic [FrameIdxWidth-1:0] frame_index,
	input  logic [MaskWidth-1:0]     task_mask,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic                     report_kind,
	input  logic [TaskIdxWidth-1:0]  report_task,
	input  logic [1:0]               task_state,
	input  logic [CountWidth-1:0]    miss_total,
	input  logic [CountWidth-1:0]    cancel_total,
	input  logic [CountWidth-1:0]    done_total,
	input  logic [HyperWidth-1:0]    hyperperiod_count,
	input  logic [MaskWidth-1:0]     released_mask,
	input  logic [MaskWidth-1:0]     demoted_mask,
	input  logic                     last,
	output int                       fail_count,
	output int                       expected_left
);

	typedef struct packed {
		logic                    kind;
		logic [TaskIdxWidth-1:0] tid;
		status_t                 st;
		count_t                  miss;
		count_t                  cancel;
		count_t                  done;
		logic [HyperWidth-1:0]   hyper;
		mask_t                   rel;
		mask_t                   dem;
		logic                    last;
	} report_t;

	report_t expected_reports[$];

	status_t                  task_status  [NumTasks];
	logic                     overrun      [NumTasks];
	count_t                   misses       [NumTasks];
	count_t                   cancels      [NumTasks];
	count_t                   dones        [NumTasks];
	mask_t                    frame_masks  [NumFrames];
	logic [FrameIdxWidth-1:0] frame_now;
	logic [HyperWidth-1:0]    hyper_done;
	logic [UseWidth-1:0]      tasks_used;
	logic [UseWidth-1:0]      frames_used;
	int                       errors;

	function automatic count_t sat_inc(input count_t c);
		return (c == '1) ? c : count_t'(c + 1'b1);
	endfunction

	function automatic logic [UseWidth-1:0] limit_use(input logic [UseWidth-1:0] v,
			input int hi);
		if (v == '0)
			return UseWidth'(1);
		if (v > hi)
			return hi[UseWidth-1:0];
		return v;
	endfunction

	task automatic queue_report(input report_t r);
		expected_reports.insert(expected_reports.size(), r);
	endtask

	task automatic reset_state();
		int i;
		for (i = 0; i < NumTasks; i++) begin
			task_status[i] = ST_IDLE;
			overrun[i]     = 1'b0;
			misses[i]      = '0;
			cancels[i]     = '0;
			dones[i]       = '0;
		end
		for (i = 0; i < NumFrames; i++)
			frame_masks[i] = '0;
		frame_now   = '0;
		hyper_done  = '0;
		tasks_used  = UseWidth'(NumTasks);
		frames_used = UseWidth'(1);
		expected_reports.delete();
	endtask

	task automatic predict_word(input logic [ReqWidth-1:0] kind,
			input logic [TaskIdxWidth-1:0] tid, input logic [FrameIdxWidth-1:0] fid,
			input mask_t m);
		mask_t               members;
		mask_t               rel;
		mask_t               dem;
		report_t             r;
		logic [UseWidth-1:0] nxt;
		int                  i;
		members = frame_masks[frame_now];
		case (kind)
			REQ_LOAD: begin
				frame_masks[fid] = m;
			end
			REQ_START: begin
				if (task_status[tid] != ST_IDLE)
					task_status[tid] = ST_RUNNING;
			end
			REQ_FINISH: begin
				task_status[tid] = ST_IDLE;
			end
			REQ_RELEASE: begin
				rel = '0;
				dem = '0;
				for (i = 0; i < tasks_used; i++) begin
					if (members[i]) begin
						if (task_status[i] == ST_IDLE) begin
							task_status[i] = ST_PENDING;
							rel[i] = 1'b1;
						end else if (task_status[i] == ST_MISSED) begin
							cancels[i] = sat_inc(cancels[i]);
						end
					end
					if (task_status[i] == ST_MISSED)
						dem[i] = 1'b1;
				end
				r       = '0;
				r.hyper = hyper_done;
				r.rel   = rel;
				r.dem   = dem;
				r.last  = 1'b1;
				queue_report(r);
			end
			REQ_END: begin
				for (i = 0; i < tasks_used; i++) begin
					case (task_status[i])
						ST_RUNNING: begin
							task_status[i] = ST_MISSED;
							overrun[i] = 1'b1;
							misses[i] = sat_inc(misses[i]);
						end
						ST_PENDING: begin
							// a pending task that overran last time is missed again
							if (overrun[i]) begin
								task_status[i] = ST_MISSED;
								misses[i] = sat_inc(misses[i]);
							end else begin
								cancels[i] = sat_inc(cancels[i]);
								task_status[i] = ST_IDLE;
							end
						end
						ST_IDLE: begin
							if (overrun[i])
								overrun[i] = 1'b0;
							else if (members[i])
								dones[i] = sat_inc(dones[i]);
						end
						default: ;
					endcase
					r        = '0;
					r.kind   = 1'b1;
					r.tid    = i[TaskIdxWidth-1:0];
					r.st     = task_status[i];
					r.miss   = misses[i];
					r.cancel = cancels[i];
					r.done   = dones[i];
					r.hyper  = hyper_done;
					r.last   = (i + 1 >= tasks_used);
					queue_report(r);
				end
				nxt = {1'b0, frame_now} + 1'b1;
				if (nxt >= frames_used || nxt >= NumFrames) begin
					frame_now  = '0;
					hyper_done = hyper_done + 1'b1;
				end else begin
					frame_now = nxt[FrameIdxWidth-1:0];
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [15:0] want_v,
			input logic [15:0] got_v);
		if (want_v !== got_v) begin
			errors++;
			if (errors <= 40)
				$display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
		end
	endtask

	task automatic check_report();
		report_t want;
		if (expected_reports.size() == 0) begin
			errors++;
			if (errors <= 40)
				$display("%0t: report word expected none actual kind %0h task %0h",
					$time, report_kind, report_task);
		end else begin
			want = expected_reports[0];
			expected_reports.delete(0);
			check_field("report_kind", 16'(want.kind), 16'(report_kind));
			check_field("report_task", 16'(want.tid), 16'(report_task));
			check_field("task_state", 16'(want.st), 16'(task_state));
			check_field("miss_total", want.miss, miss_total);
			check_field("cancel_total", want.cancel, cancel_total);
			check_field("done_total", want.done, done_total);
			check_field("hyperperiod_count", want.hyper, hyperperiod_count);
			check_field("released_mask", want.rel, released_mask);
			check_field("demoted_mask", want.dem, demoted_mask);
			check_field("last", 16'(want.last), 16'(last));
		end
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_state();
		end else begin
			// an output word accepted now belongs to an earlier input word
			if (out_valid && !out_stall)
				check_report();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TASKS:  tasks_used  = limit_use(cfg_data, NumTasks);
					CFG_FRAMES: frames_used = limit_use(cfg_data, NumFrames);
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_word(req_type, task_index, frame_index, task_mask);
		end
		fail_count    <= errors;
		expected_left <= expected_reports.size();
	end

endmodule

/* tb/sv/cyclic_frame_task_monitor_core_test.sv */
// Top of the cyclic frame task monitor testbench: stimulus, configuration and verdict.
module cyclic_frame_task_monitor_core_test;

	import cftm_pkg::*;

	// request codes the block does not know
	localparam logic [ReqWidth-1:0] REQ_SPARE_LO  = 3'd5;
	localparam logic [ReqWidth-1:0] REQ_SPARE_MID = 3'd6;
	localparam logic [ReqWidth-1:0] REQ_SPARE_HI  = 3'd7;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CfgIdxWidth-1:0]   cfg_index;
	logic [UseWidth-1:0]      cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic [ReqWidth-1:0]      req_type;
	logic [TaskIdxWidth-1:0]  task_index;
	logic [FrameIdxWidth-1:0] frame_index;
	logic [MaskWidth-1:0]     task_mask;
	logic                     out_valid;
	logic                     out_stall;
	logic                     report_kind;
	logic [TaskIdxWidth-1:0]  report_task;
	logic [1:0]               task_state;
	logic [CountWidth-1:0]    miss_total;
	logic [CountWidth-1:0]    cancel_total;
	logic [CountWidth-1:0]    done_total;
	logic [HyperWidth-1:0]    hyperperiod_count;
	logic [MaskWidth-1:0]     released_mask;
	logic [MaskWidth-1:0]     demoted_mask;
	logic                     last;

	int fail_count;
	int expected_left;
	int words_sent;
	int writes_done;
	bit idle_on;
	bit stall_on;

	cyclic_frame_task_monitor_core uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.req_type          (req_type),
		.task_index        (task_index),
		.frame_index       (frame_index),
		.task_mask         (task_mask),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.report_kind       (report_kind),
		.report_task       (report_task),
		.task_state        (task_state),
		.miss_total        (miss_total),
		.cancel_total      (cancel_total),
		.done_total        (done_total),
		.hyperperiod_count (hyperperiod_count),
		.released_mask     (released_mask),
		.demoted_mask      (demoted_mask),
		.last              (last)
	);

	cftm_report_checker watch (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.req_type          (req_type),
		.task_index        (task_index),
		.frame_index       (frame_index),
		.task_mask         (task_mask),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.report_kind       (report_kind),
		.report_task       (report_task),
		.task_state        (task_state),
		.miss_total        (miss_total),
		.cancel_total      (cancel_total),
		.done_total        (done_total),
		.hyperperiod_count (hyperperiod_count),
		.released_mask     (released_mask),
		.demoted_mask      (demoted_mask),
		.last              (last),
		.fail_count        (fail_count),
		.expected_left     (expected_left)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

	// output side backpressure in random bursts
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_word(input logic [ReqWidth-1:0] kind,
			input logic [TaskIdxWidth-1:0] tid, input logic [FrameIdxWidth-1:0] fid,
			input mask_t m);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= kind;
		task_index  <= tid;
		frame_index <= fid;
		task_mask   <= m;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (kind <= REQ_END)
			words_sent++;
	endtask

	// wait for every report, then give a silent word time to finish its busy cycles
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_left != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
			input logic [UseWidth-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		writes_done++;
		@(posedge clk);
	endtask

	function automatic logic [UseWidth-1:0] pick_use();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return UseWidth'(1);
			2: return UseWidth'(16);
			3: return '1;
			default: return UseWidth'($urandom_range(1, 16));
		endcase
	endfunction

	// low task numbers get most traffic so small task counts see starts too
	function automatic logic [TaskIdxWidth-1:0] pick_task();
		if ($urandom_range(0, 1) == 0)
			return TaskIdxWidth'($urandom_range(0, 3));
		return TaskIdxWidth'($urandom_range(0, 15));
	endfunction

	function automatic logic [TaskIdxWidth-1:0] any_task();
		return TaskIdxWidth'($urandom_range(0, 15));
	endfunction

	function automatic logic [FrameIdxWidth-1:0] any_frame();
		return FrameIdxWidth'($urandom_range(0, 15));
	endfunction

	function automatic mask_t any_mask();
		return MaskWidth'($urandom_range(0, 65535));
	endfunction

	task automatic run_frame();
		int n_ops;
		int sel;
		if ($urandom_range(0, 2) == 0)
			send_word(REQ_LOAD, pick_task(), any_frame(), any_mask());
		send_word(REQ_RELEASE, any_task(), any_frame(), any_mask());
		n_ops = $urandom_range(0, 6);
		repeat (n_ops) begin
			sel = $urandom_range(0, 9);
			if (sel < 4)
				send_word(REQ_START, pick_task(), any_frame(), any_mask());
			else if (sel < 7)
				send_word(REQ_FINISH, pick_task(), any_frame(), any_mask());
			else if (sel < 8)
				send_word(REQ_LOAD, pick_task(), any_frame(), any_mask());
			else
				send_word(ReqWidth'($urandom_range(0, 7)), any_task(), any_frame(),
					any_mask());
		end
		if ($urandom_range(0, 5) != 0)
			send_word(REQ_END, any_task(), any_frame(), any_mask());
	endtask

	initial begin
		int phase;
		int target;
		int i;
		arst_n      <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= CFG_TASKS;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		req_type    <= REQ_LOAD;
		task_index  <= '0;
		frame_index <= '0;
		task_mask   <= '0;
		words_sent  = 0;
		writes_done = 0;
		idle_on     = 1'b0;
		stall_on    = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reset settings, empty table, every status transition
		stall_on = 1'b1;
		send_word(REQ_RELEASE, 4'd0, 4'd0, 16'h0000);
		send_word(REQ_LOAD, 4'd0, 4'd0, 16'hFFFF);
		send_word(REQ_LOAD, 4'd15, 4'd15, 16'h8000);
		send_word(REQ_LOAD, 4'd0, 4'd1, 16'h0001);
		send_word(REQ_START, 4'd3, 4'd0, 16'h0000);
		send_word(REQ_RELEASE, 4'd0, 4'd0, 16'h0000);
		send_word(REQ_START, 4'd0, 4'd0, 16'h0000);
		send_word(REQ_START, 4'd15, 4'd0, 16'h0000);
		send_word(REQ_FINISH, 4'd1, 4'd0, 16'h0000);
		send_word(REQ_END, 4'd0, 4'd0, 16'h0000);
		send_word(REQ_RELEASE, 4'd0, 4'd0, 16'h0000);
		send_word(REQ_START, 4'd0, 4'd0, 16'h0000);
		send_word(REQ_END, 4'd0, 4'd0, 16'h0000);
		// finished after overrun: released again, it is missed once more
		send_word(REQ_FINISH, 4'd0, 4'd0, 16'h0000);
		send_word(REQ_RELEASE, 4'd0, 4'd0, 16'h0000);
		send_word(REQ_END, 4'd0, 4'd0, 16'h0000);
		send_word(REQ_FINISH, 4'd0, 4'd0, 16'h0000);
		send_word(REQ_END, 4'd15, 4'd15, 16'hFFFF);
		send_word(REQ_SPARE_LO, 4'd15, 4'd15, 16'hFFFF);
		send_word(REQ_SPARE_MID, 4'd0, 4'd0, 16'h0000);
		send_word(REQ_SPARE_HI, 4'd15, 4'd0, 16'hFFFF);

		// register extremes: zero becomes one and over-range values saturate
		settle();
		write_reg(CFG_TASKS, '0);
		write_reg(CFG_FRAMES, '0);
		send_word(REQ_RELEASE, 4'd0, 4'd0, 16'h0000);
		send_word(REQ_END, 4'd0, 4'd0, 16'h0000);
		settle();
		write_reg(CFG_TASKS, '1);
		write_reg(CFG_FRAMES, '1);
		for (i = 0; i < 6; i++)
			send_word(REQ_END, 4'd0, 4'd0, 16'h0000);
		// current frame now lies past the frame count: next end wraps
		settle();
		write_reg(CFG_TASKS, UseWidth'(17));
		write_reg(CFG_FRAMES, UseWidth'(2));
		send_word(REQ_END, 4'd0, 4'd0, 16'h0000);

		// random frames under several settings
		for (phase = 0; phase < 4; phase++) begin
			settle();
			write_reg(CFG_TASKS, pick_use());
			write_reg(CFG_FRAMES, pick_use());
			idle_on  = ($urandom_range(0, 3) != 0);
			stall_on = ($urandom_range(0, 3) != 0);
			target   = words_sent + 24;
			while (words_sent < target)
				run_frame();
		end

		// closing stretch with no idling on either side
		settle();
		idle_on  = 1'b0;
		stall_on = 1'b0;
		write_reg(CFG_TASKS, UseWidth'(16));
		write_reg(CFG_FRAMES, UseWidth'(3));
		target = words_sent + 20;
		while (words_sent < target)
			run_frame();
		settle();

		$display("Run covered %0d request words under %0d register writes,",
			words_sent, writes_done);
		$display("with random idling, output stalls, out-of-range settings and frame wrap.");
		if (expected_left != 0)
			$display("%0t: %0d expected reports never arrived", $time, expected_left);
		if (fail_count == 0 && expected_left == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
